// ----- hw/rtl/brt_pkg.sv -----
// shared types and constants of the run-length tokenizer
package brt_pkg;

   localparam int NEST_DEPTH    = 64;
   localparam int COUNT_BITS    = 16;
   localparam int OFFSET_BITS   = 32;
   localparam int NEST_IDX_BITS = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int DEPTH_BITS    = $clog2(NEST_DEPTH + 1);

   // a run never grows past 65535 even with a wider counter
   localparam logic [COUNT_BITS-1:0]  CNT_MAX = (COUNT_BITS >= 16) ? COUNT_BITS'(65535)
                                                                   : {COUNT_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

   localparam int OPQ_DEPTH     = 4;
   localparam int OPQ_PTR_BITS  = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_BITS  = $clog2(OPQ_DEPTH + 1);
   localparam int RSQ_DEPTH     = 4;
   localparam int RSQ_PTR_BITS  = $clog2(RSQ_DEPTH);
   localparam int RSQ_CNT_BITS  = $clog2(RSQ_DEPTH + 1);

   localparam logic [3:0] KIND_OPEN  = 4'd6;
   localparam logic [3:0] KIND_CLOSE = 4'd7;
   localparam logic [3:0] KIND_END   = 4'd8;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_UNTERM     = 2'd2;
   localparam logic [1:0] ERR_TOO_DEEP   = 2'd3;

   typedef enum logic [2:0] {
      OP_COMMENT,
      OP_RUN,
      OP_OPEN,
      OP_CLOSE,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [2:0]  run_code;
   } op_type;

   typedef struct packed {
      logic [3:0]             kind;
      logic [COUNT_BITS-1:0]  count;
      logic [OFFSET_BITS-1:0] offset;
      logic [1:0]             err;
      logic                   last;
   } token_type;

endpackage

// ----- hw/rtl/brt_ram.sv -----
// generic single-write ram with registered read
module brt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/brt_front.sv -----
// front end: byte classification and operation queue
module brt_front
   import brt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_source_byte,
   input  logic       req_end_of_source,
   input  logic       op_pop,
   output logic       op_valid,
   output op_type     op_head
);

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   op_type                  queue_ff [OPQ_DEPTH];
   logic [OPQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OPQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OPQ_CNT_BITS-1:0] cnt_ff, cnt_in;
   op_type                  op_new;
   logic                    push_ok;
   logic                    pop_ok;

   always_comb begin
      op_new.kind     = OP_COMMENT;
      op_new.run_code = 3'd0;
      if (req_end_of_source) begin
         op_new.kind = OP_END;
      end else begin
         case (req_source_byte)
            CH_LT:    begin op_new.kind = OP_RUN; op_new.run_code = 3'd0; end
            CH_GT:    begin op_new.kind = OP_RUN; op_new.run_code = 3'd1; end
            CH_PLUS:  begin op_new.kind = OP_RUN; op_new.run_code = 3'd2; end
            CH_MINUS: begin op_new.kind = OP_RUN; op_new.run_code = 3'd3; end
            CH_DOT:   begin op_new.kind = OP_RUN; op_new.run_code = 3'd4; end
            CH_COMMA: begin op_new.kind = OP_RUN; op_new.run_code = 3'd5; end
            CH_OPEN:  op_new.kind = OP_OPEN;
            CH_CLOSE: op_new.kind = OP_CLOSE;
            default:  op_new.kind = OP_COMMENT;
         endcase
      end
   end

   assign req_full = (cnt_ff == OPQ_CNT_BITS'(OPQ_DEPTH));
   assign op_valid = (cnt_ff != '0);
   assign op_head  = queue_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = op_pop && op_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OPQ_PTR_BITS'(push_ok);
      rd_ptr_in = rd_ptr_ff + OPQ_PTR_BITS'(pop_ok);
      cnt_in    = cnt_ff + OPQ_CNT_BITS'(push_ok) - OPQ_CNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

// ----- hw/rtl/brt_back.sv -----
// back end: run merging, bracket stack and token generation
module brt_back
   import brt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       op_valid,
   input  op_type     op_head,
   input  logic       room,
   output logic       op_pop,
   output token_type  tok_a,
   output token_type  tok_b,
   output logic [1:0] tok_n
);

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [2:0]             run_kind_ff, run_kind_in;
   logic                   run_active_ff, run_active_in;
   logic [COUNT_BITS-1:0]  run_len_ff, run_len_in;
   logic [OFFSET_BITS-1:0] run_start_ff, run_start_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic                   err_ff, err_in;
   logic [OFFSET_BITS-1:0] top_ff, top_in;

   logic                     exec;
   logic                     stk_we;
   logic [NEST_IDX_BITS-1:0] stk_waddr;
   logic [NEST_IDX_BITS-1:0] stk_raddr;
   logic [OFFSET_BITS-1:0]   stk_rdata;
   logic [DEPTH_BITS-1:0]    below_idx;
   token_type                flush_tok;
   token_type                own_tok;
   logic                     has_own;

   assign exec   = op_valid && room;
   assign op_pop = exec;

   always_comb begin
      flush_tok.kind   = {1'b0, run_kind_ff};
      flush_tok.count  = run_len_ff;
      flush_tok.offset = run_start_ff;
      flush_tok.err    = ERR_NONE;
      flush_tok.last   = 1'b0;
   end

   always_comb begin
      pos_in        = pos_ff;
      run_kind_in   = run_kind_ff;
      run_active_in = run_active_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      depth_in      = depth_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      stk_we        = 1'b0;
      stk_waddr     = depth_ff[NEST_IDX_BITS-1:0];
      own_tok       = '0;
      own_tok.count = COUNT_BITS'(1);
      own_tok.last  = 1'b1;
      has_own       = 1'b0;
      tok_a         = '0;
      tok_b         = '0;
      tok_n         = 2'd0;

      if (exec) begin
         if (op_head.kind == OP_END) begin
            has_own        = 1'b1;
            own_tok.kind   = KIND_END;
            own_tok.offset = pos_ff;
            if (!err_ff && depth_ff != '0) begin
               own_tok.offset = top_ff;
               own_tok.err    = ERR_UNTERM;
            end
            if (!err_ff && run_active_ff) begin
               tok_a = flush_tok;
               tok_b = own_tok;
               tok_n = 2'd2;
            end else begin
               tok_a = own_tok;
               tok_n = 2'd1;
            end
            pos_in        = '0;
            run_kind_in   = '0;
            run_active_in = 1'b0;
            run_len_in    = '0;
            run_start_in  = '0;
            depth_in      = '0;
            err_in        = 1'b0;
         end else if (!err_ff) begin
            if (pos_ff != OFS_MAX) begin
               pos_in = pos_ff + OFFSET_BITS'(1);
            end
            case (op_head.kind)
               OP_RUN: begin
                  if (run_active_ff && run_kind_ff == op_head.run_code &&
                      run_len_ff != CNT_MAX) begin
                     run_len_in = run_len_ff + COUNT_BITS'(1);
                  end else begin
                     if (run_active_ff) begin
                        tok_a      = flush_tok;
                        tok_a.last = 1'b1;
                        tok_n      = 2'd1;
                     end
                     run_active_in = 1'b1;
                     run_kind_in   = op_head.run_code;
                     run_len_in    = COUNT_BITS'(1);
                     run_start_in  = pos_ff;
                  end
               end
               OP_OPEN: begin
                  has_own        = 1'b1;
                  own_tok.kind   = KIND_OPEN;
                  own_tok.offset = pos_ff;
                  if (depth_ff == DEPTH_BITS'(NEST_DEPTH)) begin
                     own_tok.err = ERR_TOO_DEEP;
                     err_in      = 1'b1;
                  end else begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + DEPTH_BITS'(1);
                     top_in   = pos_ff;
                  end
               end
               OP_CLOSE: begin
                  has_own        = 1'b1;
                  own_tok.kind   = KIND_CLOSE;
                  own_tok.offset = pos_ff;
                  if (depth_ff == '0) begin
                     own_tok.err = ERR_UNEXPECTED;
                     err_in      = 1'b1;
                  end else begin
                     depth_in = depth_ff - DEPTH_BITS'(1);
                     top_in   = stk_rdata;
                  end
               end
               default: begin
               end
            endcase
            if (has_own) begin
               run_active_in = 1'b0;
               run_len_in    = '0;
               if (run_active_ff) begin
                  tok_a = flush_tok;
                  tok_b = own_tok;
                  tok_n = 2'd2;
               end else begin
                  tok_a = own_tok;
                  tok_n = 2'd1;
               end
            end
         end
      end
   end

   // read port tracks the entry under the top of stack
   assign below_idx = depth_in - DEPTH_BITS'(2);
   assign stk_raddr = below_idx[NEST_IDX_BITS-1:0];

   brt_ram #(
      .WIDTH (OFFSET_BITS),
      .DEPTH (NEST_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (pos_ff),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         run_kind_ff   <= '0;
         run_active_ff <= 1'b0;
         run_len_ff    <= '0;
         run_start_ff  <= '0;
         depth_ff      <= '0;
         err_ff        <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         run_kind_ff   <= run_kind_in;
         run_active_ff <= run_active_in;
         run_len_ff    <= run_len_in;
         run_start_ff  <= run_start_in;
         depth_ff      <= depth_in;
         err_ff        <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

endmodule

// ----- hw/rtl/brt_out_fifo.sv -----
// result queue taking up to two tokens per cycle
module brt_out_fifo
   import brt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] tok_n,
   input  token_type  tok_a,
   input  token_type  tok_b,
   output logic       room,
   input  logic       pop,
   output logic       empty,
   output token_type  head
);

   token_type               queue_ff [RSQ_DEPTH];
   logic [RSQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSQ_PTR_BITS-1:0] wr_ptr_next;
   logic [RSQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSQ_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    pop_ok;

   assign empty       = (cnt_ff == '0);
   assign room        = (cnt_ff <= RSQ_CNT_BITS'(RSQ_DEPTH - 2));
   assign head        = queue_ff[rd_ptr_ff];
   assign pop_ok      = pop && !empty;
   assign wr_ptr_next = wr_ptr_ff + RSQ_PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSQ_PTR_BITS'(tok_n);
      rd_ptr_in = rd_ptr_ff + RSQ_PTR_BITS'(pop_ok);
      cnt_in    = cnt_ff + RSQ_CNT_BITS'(tok_n) - RSQ_CNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= tok_a;
      end
      if (tok_n == 2'd2) begin
         queue_ff[wr_ptr_next] <= tok_b;
      end
   end

endmodule

// ----- hw/rtl/bf_run_length_tokenizer.sv -----
// top level of the run-length tokenizer for bracket-language source text
//
//  channel   direction  handshake          beat
//  req       in         push / full        source_byte, end_of_source
//  rsp       out        pop / empty        token_kind, run_count, token_offset,
//                                          error_code, last_of_item
//
// one byte is taken per cycle unless req_full; its result passes both queue registers
// the back end retires one operation per cycle when the result queue has room
// for two tokens, so the sustained rate is set by rsp draining one token a cycle
// an item that makes two tokens takes two entries of the result queue
// reset empties both queues and clears the tokenizer state but for top_ff and the stack ram
// either side may stall freely; the four-entry queues absorb the difference
module bf_run_length_tokenizer
   import brt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_source_byte,
   input  logic                   req_end_of_source,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic [3:0]             rsp_token_kind,
   output logic [COUNT_BITS-1:0]  rsp_run_count,
   output logic [OFFSET_BITS-1:0] rsp_token_offset,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last_of_item
);

   logic       op_pop;
   logic       op_valid;
   op_type     op_head;
   logic       room;
   token_type  tok_a;
   token_type  tok_b;
   logic [1:0] tok_n;
   token_type  head;

   brt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_source_byte   (req_source_byte),
      .req_end_of_source (req_end_of_source),
      .op_pop            (op_pop),
      .op_valid          (op_valid),
      .op_head           (op_head)
   );

   brt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_head  (op_head),
      .room     (room),
      .op_pop   (op_pop),
      .tok_a    (tok_a),
      .tok_b    (tok_b),
      .tok_n    (tok_n)
   );

   brt_out_fifo u_out (
      .clock (clock),
      .reset (reset),
      .tok_n (tok_n),
      .tok_a (tok_a),
      .tok_b (tok_b),
      .room  (room),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .head  (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_run_count    = head.count;
   assign rsp_token_offset = head.offset;
   assign rsp_error_code   = head.err;
   assign rsp_last_of_item = head.last;

   // end token always closes its item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_token_kind == KIND_END |-> rsp_last_of_item)
      else $error("end token without last flag");

   // errors only ride on bracket or end tokens
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_error_code != ERR_NONE |->
         (rsp_token_kind == KIND_OPEN || rsp_token_kind == KIND_CLOSE ||
          rsp_token_kind == KIND_END))
      else $error("error code on a run token");

   // tokens are only written when the result queue had room for two of them
   a_room: assert property (@(posedge clock) disable iff (reset)
      tok_n != 2'd0 |-> room && op_valid)
      else $error("token written without room");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule
